// File: hdl/lbtc_pkg.sv
// Shared types and constants of the line buffer tab compressor.
`timescale 1ns / 1ps

package lbtc_pkg;

    // Item kinds carried on the slave-side tuser.
    typedef enum logic [1:0] {
        KIND_CHAR    = 2'd0,
        KIND_FLUSH   = 2'd1,
        KIND_ENDLINE = 2'd2
    } t_kind;

    // Input controller states.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_TAB  = 1'b1
    } t_top_state;

    // Emitter sequencer states.
    typedef enum logic [2:0] {
        E_IDLE  = 3'd0,
        E_FETCH = 3'd1,
        E_DATA  = 3'd2,
        E_PEND  = 3'd3,
        E_NL    = 3'd4
    } t_emit_state;

    // Command from the input controller to the emitter.
    typedef struct packed {
        logic start;
        logic raw;
    } t_emit_cmd;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned WRAP_W     = 7;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned SPACE_W    = 4;
    localparam int unsigned RAW_MARGIN = 9;

    localparam logic [BYTE_W-1:0] BYTE_NUL = 8'd0;
    localparam logic [BYTE_W-1:0] BYTE_TAB = 8'd9;
    localparam logic [BYTE_W-1:0] BYTE_NL  = 8'd10;
    localparam logic [BYTE_W-1:0] BYTE_SP  = 8'd32;

    localparam logic [WRAP_W-1:0]  WRAP_RESET  = 7'd48;
    localparam logic [SPACE_W-1:0] SPACE_LIMIT = 4'd8;

endpackage

// File: hdl/lbtc_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
`timescale 1ns / 1ps

module lbtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/lbtc_emitter.sv
// Read-out sequencer: replays the line store raw or with space runs compressed to tabs.
`timescale 1ns / 1ps

module lbtc_emitter #(
    parameter int LINE_CAPACITY = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lbtc_pkg::t_emit_cmd              i_cmd,
    input  logic [$clog2(LINE_CAPACITY)-1:0] i_len,
    output logic                             o_busy,
    output logic                             o_rd_en,
    output logic [$clog2(LINE_CAPACITY)-1:0] o_rd_addr,
    input  logic [lbtc_pkg::BYTE_W-1:0]      i_rd_data,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [lbtc_pkg::BYTE_W-1:0]      o_m_tdata,   // out_byte
    output logic                             o_m_tlast    // last
);

    localparam int ADDR_W    = $clog2(LINE_CAPACITY);
    localparam int TAB_CNT_W = $clog2(LINE_CAPACITY / 8 + 1);

    lbtc_pkg::t_emit_state r_state, n_state;
    logic [ADDR_W-1:0]            r_p, n_p;
    logic [ADDR_W-1:0]            r_len, n_len;
    logic                         r_raw, n_raw;
    logic [TAB_CNT_W-1:0]         r_tabs, n_tabs;
    logic [lbtc_pkg::SPACE_W-1:0] r_spaces, n_spaces;
    logic [lbtc_pkg::BYTE_W-1:0]  r_char, n_char;
    logic                         r_valid, n_valid;
    logic [lbtc_pkg::BYTE_W-1:0]  r_data, n_data;
    logic                         r_last, n_last;

    logic                         out_free;
    logic [ADDR_W-1:0]            p_inc;
    logic                         last_pos;
    logic                         boundary;
    logic [TAB_CNT_W-1:0]         t_tabs;
    logic [lbtc_pkg::SPACE_W-1:0] t_spaces;

    assign out_free = !r_valid || i_m_tready;
    assign p_inc    = r_p + 1'b1;
    assign last_pos = (p_inc == r_len);
    // A pending space run that reaches a tab stop is folded into one tab.
    assign boundary = (r_p[2:0] == 3'd0) && (r_spaces != '0);
    assign t_tabs   = r_tabs + TAB_CNT_W'(boundary);
    assign t_spaces = boundary ? '0 : r_spaces;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lbtc_pkg::E_IDLE;
            r_valid  <= 1'b0;
            r_tabs   <= '0;
            r_spaces <= '0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_tabs   <= n_tabs;
            r_spaces <= n_spaces;
        end
        r_p      <= n_p;
        r_len    <= n_len;
        r_raw    <= n_raw;
        r_char   <= n_char;
        r_data   <= n_data;
        r_last   <= n_last;
    end

    always_comb begin
        n_state  = r_state;
        n_p      = r_p;
        n_len    = r_len;
        n_raw    = r_raw;
        n_tabs   = r_tabs;
        n_spaces = r_spaces;
        n_char   = r_char;
        n_valid  = r_valid && !i_m_tready;
        n_data   = r_data;
        n_last   = r_last;
        o_rd_en  = 1'b0;
        case (r_state)
            lbtc_pkg::E_IDLE: begin
                if (i_cmd.start) begin
                    n_len    = i_len;
                    n_raw    = i_cmd.raw;
                    n_p      = '0;
                    n_tabs   = '0;
                    n_spaces = '0;
                    n_state  = (i_len == '0) ? lbtc_pkg::E_NL : lbtc_pkg::E_FETCH;
                end
            end
            lbtc_pkg::E_FETCH: begin
                o_rd_en = 1'b1;
                n_state = lbtc_pkg::E_DATA;
            end
            lbtc_pkg::E_DATA: begin
                if (r_raw) begin
                    if (out_free) begin
                        n_valid = 1'b1;
                        n_data  = i_rd_data;
                        n_last  = last_pos;
                        n_p     = p_inc;
                        n_state = last_pos ? lbtc_pkg::E_IDLE : lbtc_pkg::E_FETCH;
                    end
                end else begin
                    n_tabs   = t_tabs;
                    n_spaces = t_spaces;
                    if (i_rd_data == lbtc_pkg::BYTE_SP) begin
                        n_spaces = t_spaces + 1'b1;
                        n_p      = p_inc;
                        n_state  = last_pos ? lbtc_pkg::E_NL : lbtc_pkg::E_FETCH;
                    end else begin
                        n_char  = i_rd_data;
                        n_state = lbtc_pkg::E_PEND;
                    end
                end
            end
            lbtc_pkg::E_PEND: begin
                if (out_free) begin
                    n_valid = 1'b1;
                    n_last  = 1'b0;
                    if (r_tabs != '0) begin
                        n_data = lbtc_pkg::BYTE_TAB;
                        n_tabs = r_tabs - 1'b1;
                    end else if (r_spaces != '0) begin
                        n_data   = lbtc_pkg::BYTE_SP;
                        n_spaces = r_spaces - 1'b1;
                    end else begin
                        n_data  = r_char;
                        n_p     = p_inc;
                        n_state = last_pos ? lbtc_pkg::E_NL : lbtc_pkg::E_FETCH;
                    end
                end
            end
            lbtc_pkg::E_NL: begin
                if (out_free) begin
                    n_valid = 1'b1;
                    n_data  = lbtc_pkg::BYTE_NL;
                    n_last  = 1'b1;
                    n_state = lbtc_pkg::E_IDLE;
                end
            end
            default: begin
                n_state = lbtc_pkg::E_IDLE;
            end
        endcase
    end

    assign o_busy     = (r_state != lbtc_pkg::E_IDLE);
    assign o_rd_addr  = r_p;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tlast  = r_last;

`ifndef NO_ASSERTIONS
    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> (r_state == lbtc_pkg::E_IDLE))
        else $error("emitter started while a replay is in progress");

    a_space_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_spaces <= lbtc_pkg::SPACE_LIMIT)
        else $error("pending space run crossed a tab stop");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd_en |-> (r_p < r_len))
        else $error("store read beyond the line length");
`endif

endmodule

// File: hdl/line_buffer_tab_compressor.sv
// Top level of the line buffer tab compressor: input control, line store and emitter.
// Throughput: one item a cycle unless a tab or replay runs; a tab fills one column per cycle.
// Replay: each stored byte is read from the store; in a compressed line pending tabs and
// spaces go out before each kept byte and a newline comes last. A held output stalls the
// replay. No item is taken until the last byte is loaded. Reset (i_rst_n, synchronous,
// active low) clears the fill and sets wrap_column to 48.
`timescale 1ns / 1ps

// The block collects printable characters in a line store indexed by the fill
// position. A tab is expanded in place by writing one space per cycle until the
// fill reaches a multiple of eight, and a NUL is dropped. A newline, a flush of a
// non-empty line, or an end-line request with the fill at or past the wrap column
// hands the stored line to the emitter, which compresses space runs that reach a
// tab stop into tabs, drops trailing spaces and finishes with a newline marked by
// tlast. When the fill reaches the capacity less nine, the stored bytes are
// replayed unchanged as one transfer run and the store restarts. An item with its
// fault flag set is accepted and discarded. The store contents are not cleared by
// reset; only entries below the fill are ever read, and those have been written.

module line_buffer_tab_compressor #(
    parameter int LINE_CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Slave side: one input item per transfer.
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,    // ch
    input  logic [2:0] i_s_tuser,    // kind [1:0], fault_pending [2]
    // Master side: one emitted byte per transfer.
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,    // out_byte
    output logic       o_m_tlast,    // last
    // Configuration: wrap_column.
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [6:0] i_cfg_data
);

    localparam int ADDR_W    = $clog2(LINE_CAPACITY);
    localparam int RAW_LIMIT = LINE_CAPACITY - lbtc_pkg::RAW_MARGIN;

    lbtc_pkg::t_top_state        r_state, n_state;
    logic [ADDR_W-1:0]           r_fill, n_fill;
    logic [lbtc_pkg::WRAP_W-1:0] r_wrap;

    logic                        accept;
    logic                        fault;
    lbtc_pkg::t_kind             kind;
    logic [ADDR_W-1:0]           fill_inc;
    logic                        settle;
    logic                        wr_en;
    logic [lbtc_pkg::BYTE_W-1:0] wr_data;
    lbtc_pkg::t_emit_cmd         cmd;
    logic [ADDR_W-1:0]           emit_len;
    logic                        emit_busy;
    logic                        rd_en;
    logic [ADDR_W-1:0]           rd_addr;
    logic [lbtc_pkg::BYTE_W-1:0] rd_data;

    assign accept   = i_s_tvalid && o_s_tready;
    assign fault    = i_s_tuser[2];
    assign kind     = lbtc_pkg::t_kind'(i_s_tuser[lbtc_pkg::KIND_W-1:0]);
    assign fill_inc = r_fill + 1'b1;

    // Items are taken only when no tab expansion and no replay is in progress.
    assign o_s_tready  = (r_state == lbtc_pkg::S_IDLE) && !emit_busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lbtc_pkg::S_IDLE;
            r_fill  <= '0;
            r_wrap  <= lbtc_pkg::WRAP_RESET;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (i_cfg_valid && o_cfg_ready) begin
                r_wrap <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        wr_en     = 1'b0;
        wr_data   = i_s_tdata;
        cmd.start = 1'b0;
        cmd.raw   = 1'b0;
        emit_len  = r_fill;
        settle    = 1'b0;
        case (r_state)
            lbtc_pkg::S_IDLE: begin
                if (accept && !fault) begin
                    case (kind)
                        lbtc_pkg::KIND_CHAR: begin
                            case (i_s_tdata)
                                lbtc_pkg::BYTE_NL: begin
                                    cmd.start = 1'b1;
                                    n_fill    = '0;
                                end
                                lbtc_pkg::BYTE_TAB: begin
                                    wr_en   = 1'b1;
                                    wr_data = lbtc_pkg::BYTE_SP;
                                    if (fill_inc[2:0] != 3'd0) begin
                                        n_fill  = fill_inc;
                                        n_state = lbtc_pkg::S_TAB;
                                    end else begin
                                        settle = 1'b1;
                                    end
                                end
                                lbtc_pkg::BYTE_NUL: begin
                                end
                                default: begin
                                    wr_en  = 1'b1;
                                    settle = 1'b1;
                                end
                            endcase
                        end
                        lbtc_pkg::KIND_FLUSH: begin
                            if (r_fill != '0) begin
                                cmd.start = 1'b1;
                                n_fill    = '0;
                            end
                        end
                        lbtc_pkg::KIND_ENDLINE: begin
                            if (lbtc_pkg::WRAP_W'(r_fill) >= r_wrap) begin
                                cmd.start = 1'b1;
                                n_fill    = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            lbtc_pkg::S_TAB: begin
                // One space per cycle until the next tab stop.
                wr_en   = 1'b1;
                wr_data = lbtc_pkg::BYTE_SP;
                if (fill_inc[2:0] != 3'd0) begin
                    n_fill = fill_inc;
                end else begin
                    settle  = 1'b1;
                    n_state = lbtc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lbtc_pkg::S_IDLE;
            end
        endcase
        // After the last store write of an item, a full store is replayed raw.
        if (settle) begin
            if (fill_inc >= ADDR_W'(RAW_LIMIT)) begin
                cmd.start = 1'b1;
                cmd.raw   = 1'b1;
                emit_len  = fill_inc;
                n_fill    = '0;
            end else begin
                n_fill = fill_inc;
            end
        end
    end

    lbtc_ram #(
        .WIDTH (lbtc_pkg::BYTE_W),
        .DEPTH (LINE_CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lbtc_emitter #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_emitter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_len      (emit_len),
        .o_busy     (emit_busy),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

`ifndef NO_ASSERTIONS
    a_fill_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lbtc_pkg::S_IDLE) |-> (r_fill < ADDR_W'(RAW_LIMIT)))
        else $error("fill at the raw limit while waiting for an item");

    a_start_clears_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start |=> (r_fill == '0))
        else $error("fill not restarted after a replay was started");

    a_tab_mid_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lbtc_pkg::S_TAB) |-> (r_fill[2:0] != 3'd0))
        else $error("tab expansion running at a tab stop");

    a_no_write_in_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> !emit_busy)
        else $error("line store written during a replay");
`endif

endmodule
